@@ hw/rtl/bnms_pkg.sv @@
`timescale 1ns / 1ps
package bnms_pkg;
	localparam int MaxBoxes = 64;
	localparam int MaxClasses = 16;
	localparam int BoxW = $clog2(MaxBoxes);
	localparam int ClsW = $clog2(MaxClasses);
	localparam int ScoreAw = BoxW + ClsW;

	localparam logic [1:0] OP_LOAD_BOX = 2'd0;
	localparam logic [1:0] OP_LOAD_SCORE = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_CLASSES = 1'b1;

	typedef struct packed {
		logic load_box;
		logic load_score;
		logic read_score;
		logic sc_rd;
		logic [BoxW-1:0] sc_box;
		logic [ClsW-1:0] sc_cls;
		logic ge_rd_a;
		logic ge_rd_b;
		logic [BoxW-1:0] ge_box;
		logic zero_b;
		logic rk_we;
		logic [BoxW-1:0] rk_addr;
		logic [BoxW-1:0] rk_wdata;
	} bnms_cmd_t;

	typedef struct packed {
		logic [15:0] sc_data;
		logic [BoxW-1:0] rk_data;
		logic present;
		logic over;
	} bnms_sts_t;
endpackage

@@ hw/rtl/bnms_datapath.sv @@
`timescale 1ns / 1ps
module bnms_datapath (
	input logic clk,
	input logic arst_n,
	input bnms_pkg::bnms_cmd_t cmd,
	output bnms_pkg::bnms_sts_t sts,
	input logic [bnms_pkg::BoxW-1:0] box_index,
	input logic [bnms_pkg::ClsW-1:0] class_index,
	input logic [15:0] center_x,
	input logic [15:0] center_y,
	input logic [15:0] box_width,
	input logic [15:0] box_height,
	input logic box_present,
	input logic [15:0] score_in,
	input logic [15:0] iou_threshold
);
	logic [63:0] geo_mem [bnms_pkg::MaxBoxes];
	logic [15:0] sc_mem [bnms_pkg::MaxBoxes * bnms_pkg::MaxClasses];
	logic [bnms_pkg::BoxW-1:0] rk_mem [bnms_pkg::MaxBoxes];
	logic [bnms_pkg::MaxBoxes-1:0] pres_q;
	logic [63:0] ga_q, gb_q;
	logic [15:0] sc_rd_q;
	logic [bnms_pkg::BoxW-1:0] rk_rd_q;
	logic [bnms_pkg::ScoreAw-1:0] sc_addr;
	logic signed [18:0] ow_s1, oh_s1;
	logic [31:0] aa_s1, ab_s1;
	logic signed [37:0] i4_s2;
	logic [33:0] a4_s2, b4_s2;
	logic [37:0] i4p;
	logic [35:0] u4_s3;
	logic [37:0] i4_s3;
	logic [53:0] lhs_s4;
	logic [51:0] rhs_s4;
	logic over_q;

	function automatic logic signed [18:0] overlap(input logic [15:0] ca,
			input logic [15:0] sa, input logic [15:0] cb, input logic [15:0] sb);
		logic signed [18:0] la, ra, lb, rb, l, r;
		la = $signed({2'b0, ca, 1'b0}) - $signed({3'b0, sa});
		ra = $signed({2'b0, ca, 1'b0}) + $signed({3'b0, sa});
		lb = $signed({2'b0, cb, 1'b0}) - $signed({3'b0, sb});
		rb = $signed({2'b0, cb, 1'b0}) + $signed({3'b0, sb});
		l = (la > lb) ? la : lb;
		r = (ra < rb) ? ra : rb;
		return r - l;
	endfunction

	assign sc_addr = cmd.load_score || cmd.read_score ? {box_index, class_index}
		: {cmd.sc_box, cmd.sc_cls};

	always_ff @(posedge clk) begin
		if (cmd.load_box)
			geo_mem[box_index] <= {center_x, center_y, box_width, box_height};
		if (cmd.load_score)
			sc_mem[sc_addr] <= score_in;
		else if (cmd.zero_b)
			sc_mem[sc_addr] <= 16'd0;
		if (cmd.sc_rd || cmd.read_score)
			sc_rd_q <= sc_mem[sc_addr];
		if (cmd.rk_we)
			rk_mem[cmd.rk_addr] <= cmd.rk_wdata;
		rk_rd_q <= rk_mem[cmd.rk_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pres_q <= '0;
		else if (cmd.load_box)
			pres_q[box_index] <= box_present;
	end

	always_ff @(posedge clk) begin
		if (cmd.ge_rd_a)
			ga_q <= geo_mem[cmd.ge_box];
		if (cmd.ge_rd_b)
			gb_q <= geo_mem[cmd.ge_box];
		ow_s1 <= overlap(ga_q[63:48], ga_q[31:16], gb_q[63:48], gb_q[31:16]);
		oh_s1 <= overlap(ga_q[47:32], ga_q[15:0], gb_q[47:32], gb_q[15:0]);
		aa_s1 <= ga_q[31:16] * ga_q[15:0];
		ab_s1 <= gb_q[31:16] * gb_q[15:0];
		i4_s2 <= (ow_s1 > 0 && oh_s1 > 0) ? 38'(ow_s1 * oh_s1) : 38'sd0;
		a4_s2 <= {aa_s1, 2'b0};
		b4_s2 <= {ab_s1, 2'b0};
		i4_s3 <= i4p;
		u4_s3 <= 36'({2'b0, a4_s2} + {2'b0, b4_s2} - i4p[35:0]);
		lhs_s4 <= {i4_s3[37:0], 16'd0};
		rhs_s4 <= iou_threshold * u4_s3;
		over_q <= {2'b0, lhs_s4} > {4'b0, rhs_s4};
	end
	assign i4p = i4_s2;

	assign sts.sc_data = sc_rd_q;
	assign sts.rk_data = rk_rd_q;
	assign sts.present = pres_q[cmd.sc_box];
	assign sts.over = over_q;
endmodule

@@ hw/rtl/bnms_ctrl.sv @@
`timescale 1ns / 1ps
module bnms_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] op,
	input logic [6:0] box_total,
	input logic [4:0] class_count,
	output logic busy,
	output logic strobe,
	output logic run_done,
	output logic read_sel,
	output bnms_pkg::bnms_cmd_t cmd,
	input bnms_pkg::bnms_sts_t sts
);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_READ = 4'd1, ST_CLS = 4'd2,
		ST_INS_RD = 4'd3, ST_INS_W = 4'd4, ST_INS_CMP = 4'd5, ST_A_RD = 4'd6,
		ST_A_W = 4'd7, ST_A_CHK = 4'd8, ST_B_RD = 4'd9, ST_B_W = 4'd10,
		ST_B_CHK = 4'd11, ST_IOU = 4'd12, ST_DONE = 4'd13, ST_INS_K = 4'd14,
		ST_A_G = 4'd15;
	localparam int CntW = bnms_pkg::BoxW + 1;

	logic [3:0] st_q;
	logic [CntW-1:0] tot_q, i_q, j_q, n_q;
	logic [bnms_pkg::ClsW:0] k_q, kmax_q;
	logic [bnms_pkg::BoxW-1:0] a_q, b_q;
	logic [15:0] s_q;
	logic [2:0] w_q;
	logic acc;

	assign acc = start && !busy;
	assign busy = st_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			strobe <= 1'b0;
			run_done <= 1'b0;
			read_sel <= 1'b0;
			tot_q <= '0; i_q <= '0; j_q <= '0; n_q <= '0;
			k_q <= '0; kmax_q <= '0; a_q <= '0; b_q <= '0; s_q <= '0; w_q <= '0;
		end else begin
			strobe <= 1'b0;
			run_done <= 1'b0;
			read_sel <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						if (op == bnms_pkg::OP_RUN) begin
							tot_q <= (box_total > 7'(bnms_pkg::MaxBoxes)) ?
								CntW'(bnms_pkg::MaxBoxes) : CntW'(box_total);
							kmax_q <= (class_count > 5'(bnms_pkg::MaxClasses)) ?
								(bnms_pkg::ClsW+1)'(bnms_pkg::MaxClasses)
								: (bnms_pkg::ClsW+1)'(class_count);
							k_q <= '0;
							st_q <= ST_CLS;
						end else if (op == bnms_pkg::OP_READ) begin
							st_q <= ST_READ;
						end else begin
							strobe <= 1'b1;
						end
					end
				end
				ST_READ: begin
					strobe <= 1'b1;
					read_sel <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_CLS: begin
					if (k_q >= kmax_q) begin
						st_q <= ST_DONE;
					end else begin
						i_q <= '0;
						n_q <= '0;
						st_q <= ST_INS_RD;
					end
				end
				ST_INS_RD: begin
					if (i_q >= tot_q) begin
						i_q <= '0;
						st_q <= ST_A_RD;
					end else if (!sts.present) begin
						i_q <= i_q + 1'b1;
					end else begin
						st_q <= ST_INS_W;
					end
				end
				ST_INS_W: begin
					s_q <= sts.sc_data;
					j_q <= n_q;
					st_q <= ST_INS_K;
				end
				ST_INS_K: begin
					if (j_q == '0) begin
						st_q <= ST_INS_CMP;
					end else begin
						w_q <= 3'd0;
						st_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					// Walk down the rank list one entry per pass; w_q sequences reads.
					if (j_q == '0) begin
						n_q <= n_q + 1'b1;
						i_q <= i_q + 1'b1;
						st_q <= ST_INS_RD;
					end else if (w_q < 3'd3) begin
						w_q <= w_q + 1'b1;
					end else if (sts.sc_data < s_q) begin
						j_q <= j_q - 1'b1;
						w_q <= 3'd0;
					end else begin
						n_q <= n_q + 1'b1;
						i_q <= i_q + 1'b1;
						st_q <= ST_INS_RD;
					end
				end
				ST_A_RD: begin
					if (i_q >= n_q) begin
						k_q <= k_q + 1'b1;
						st_q <= ST_CLS;
					end else begin
						w_q <= 3'd0;
						st_q <= ST_A_W;
					end
				end
				ST_A_W: begin
					if (w_q < 3'd2) begin
						w_q <= w_q + 1'b1;
						a_q <= sts.rk_data;
					end else begin
						st_q <= ST_A_CHK;
						w_q <= 3'd0;
					end
				end
				ST_A_CHK: begin
					if (w_q < 3'd1) begin
						w_q <= w_q + 1'b1;
					end else if (sts.sc_data == 16'd0) begin
						i_q <= i_q + 1'b1;
						st_q <= ST_A_RD;
					end else begin
						st_q <= ST_A_G;
					end
				end
				ST_A_G: begin
					j_q <= i_q + 1'b1;
					st_q <= ST_B_RD;
				end
				ST_B_RD: begin
					if (j_q >= n_q) begin
						i_q <= i_q + 1'b1;
						st_q <= ST_A_RD;
					end else begin
						w_q <= 3'd0;
						st_q <= ST_B_W;
					end
				end
				ST_B_W: begin
					if (w_q < 3'd2) begin
						w_q <= w_q + 1'b1;
						b_q <= sts.rk_data;
					end else begin
						w_q <= 3'd0;
						st_q <= ST_B_CHK;
					end
				end
				ST_B_CHK: begin
					if (w_q < 3'd1) begin
						w_q <= w_q + 1'b1;
					end else if (sts.sc_data == 16'd0) begin
						j_q <= j_q + 1'b1;
						st_q <= ST_B_RD;
					end else begin
						w_q <= 3'd0;
						st_q <= ST_IOU;
					end
				end
				ST_IOU: begin
					if (w_q < 3'd6) begin
						w_q <= w_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
						st_q <= ST_B_RD;
					end
				end
				ST_DONE: begin
					strobe <= 1'b1;
					run_done <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.sc_cls = k_q[bnms_pkg::ClsW-1:0];
		cmd.sc_box = i_q[bnms_pkg::BoxW-1:0];
		cmd.rk_addr = j_q[bnms_pkg::BoxW-1:0];
		cmd.ge_box = a_q;
		if (acc && op == bnms_pkg::OP_LOAD_BOX)
			cmd.load_box = 1'b1;
		if (acc && op == bnms_pkg::OP_LOAD_SCORE)
			cmd.load_score = 1'b1;
		if (acc && op == bnms_pkg::OP_READ)
			cmd.read_score = 1'b1;
		case (st_q)
			ST_INS_RD: cmd.sc_rd = 1'b1;
			ST_INS_K: begin
				cmd.rk_addr = j_q[bnms_pkg::BoxW-1:0] - 1'b1;
			end
			ST_INS_CMP: begin
				cmd.rk_addr = j_q[bnms_pkg::BoxW-1:0] - 1'b1;
				cmd.sc_box = sts.rk_data;
				cmd.sc_rd = 1'b1;
				if (j_q == '0 || (w_q == 3'd3 && !(sts.sc_data < s_q))) begin
					cmd.rk_we = 1'b1;
					cmd.rk_addr = j_q[bnms_pkg::BoxW-1:0];
					cmd.rk_wdata = i_q[bnms_pkg::BoxW-1:0];
				end else if (w_q == 3'd3) begin
					cmd.rk_we = 1'b1;
					cmd.rk_addr = j_q[bnms_pkg::BoxW-1:0];
					cmd.rk_wdata = sts.rk_data;
				end
			end
			ST_A_RD, ST_A_W: cmd.rk_addr = i_q[bnms_pkg::BoxW-1:0];
			ST_A_CHK: begin
				cmd.sc_box = a_q;
				cmd.sc_rd = 1'b1;
			end
			ST_A_G: cmd.ge_rd_a = 1'b1;
			ST_B_RD, ST_B_W: cmd.rk_addr = j_q[bnms_pkg::BoxW-1:0];
			ST_B_CHK: begin
				cmd.sc_box = b_q;
				cmd.sc_rd = 1'b1;
				cmd.ge_box = b_q;
				cmd.ge_rd_b = 1'b1;
			end
			ST_IOU: begin
				cmd.sc_box = b_q;
				if (w_q == 3'd6 && sts.over)
					cmd.zero_b = 1'b1;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> !busy);
	assert property (@(posedge clk) disable iff (!arst_n) run_done |-> strobe);
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == bnms_pkg::OP_RUN) |=> busy);
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.zero_b |-> st_q == ST_IOU);
endmodule

@@ hw/rtl/box_non_max_suppression.sv @@
`timescale 1ns / 1ps
// Load items strobe their result in the cycle after acceptance, read items after a read state.
// A run works class by class: it skips absent boxes, insertion-sorts the present boxes by
// score into a rank list, then compares each ranked box of nonzero score with every lower
// ranked box of nonzero score and zeroes the lower score where the IoU is over threshold.
// One item is in work at a time; busy is high from acceptance of a read or run until
// its result strobe. The receiver cannot stall. Reset clears the control state, the
// present flags and the registers to threshold 29491 and one class.
module box_non_max_suppression (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic strobe,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data,
	input logic [1:0] op,
	input logic [5:0] box_index,
	input logic [3:0] class_index,
	input logic [15:0] center_x,
	input logic [15:0] center_y,
	input logic [15:0] box_width,
	input logic [15:0] box_height,
	input logic box_present,
	input logic [15:0] score_in,
	input logic [6:0] box_total,
	output logic run_done,
	output logic [15:0] score_out
);
	logic [15:0] thr_q;
	logic [4:0] ccnt_q;
	logic read_sel;
	bnms_pkg::bnms_cmd_t cmd;
	bnms_pkg::bnms_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd29491;
			ccnt_q <= 5'd1;
		end else if (cfg_we) begin
			if (cfg_index == bnms_pkg::CFG_THRESHOLD)
				thr_q <= cfg_data;
			else
				ccnt_q <= cfg_data[4:0];
		end
	end

	bnms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .box_total(box_total),
		.class_count(ccnt_q), .busy(busy), .strobe(strobe), .run_done(run_done),
		.read_sel(read_sel), .cmd(cmd), .sts(sts)
	);

	bnms_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .box_index(box_index),
		.class_index(class_index), .center_x(center_x), .center_y(center_y),
		.box_width(box_width), .box_height(box_height), .box_present(box_present),
		.score_in(score_in), .iou_threshold(thr_q)
	);

	assign score_out = read_sel ? sts.sc_data : 16'd0;
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	typedef struct {
		logic [1:0] op;
		logic [5:0] box_index;
		logic [3:0] class_index;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic box_present;
		logic [15:0] score_in;
		logic [6:0] box_total;
	} nms_txn_t;

	typedef struct {
		logic run_done;
		logic [15:0] score_out;
	} nms_reply_t;

	class nms_scoreboard;
		logic [15:0] bx[bnms_pkg::MaxBoxes];
		logic [15:0] by[bnms_pkg::MaxBoxes];
		logic [15:0] bw[bnms_pkg::MaxBoxes];
		logic [15:0] bh[bnms_pkg::MaxBoxes];
		bit present[bnms_pkg::MaxBoxes];
		logic [15:0] score[bnms_pkg::MaxBoxes][bnms_pkg::MaxClasses];
		bit score_set[bnms_pkg::MaxBoxes][bnms_pkg::MaxClasses];
		logic [15:0] threshold;
		logic [4:0] class_count;
		nms_reply_t expected_q[$];
		int errors;

		function new();
			threshold = 16'd29491;
			class_count = 5'd1;
			errors = 0;
			for (int i = 0; i < bnms_pkg::MaxBoxes; i++) begin
				present[i] = 1'b0;
				for (int c = 0; c < bnms_pkg::MaxClasses; c++)
					score_set[i][c] = 1'b0;
			end
		endfunction

		function longint overlap(logic [15:0] ca, logic [15:0] sa, logic [15:0] cb,
				logic [15:0] sb);
			longint la, ra, lb, rb, lo, hi;
			la = 2 * longint'(ca) - longint'(sa);
			ra = 2 * longint'(ca) + longint'(sa);
			lb = 2 * longint'(cb) - longint'(sb);
			rb = 2 * longint'(cb) + longint'(sb);
			lo = la > lb ? la : lb;
			hi = ra < rb ? ra : rb;
			return hi - lo;
		endfunction

		function bit iou_over(int a, int b);
			longint ow, oh, i4, u4;
			ow = overlap(bx[a], bw[a], bx[b], bw[b]);
			oh = overlap(by[a], bh[a], by[b], bh[b]);
			i4 = 0;
			if (ow > 0 && oh > 0)
				i4 = ow * oh;
			u4 = 4 * (longint'(bw[a]) * longint'(bh[a]))
				+ 4 * (longint'(bw[b]) * longint'(bh[b])) - i4;
			return i4 * 65536 > longint'(threshold) * u4;
		endfunction

		function void suppress(int tot);
			int classes, n, j, a, b;
			int rank[bnms_pkg::MaxBoxes];
			logic [15:0] s;
			classes = class_count > bnms_pkg::MaxClasses ? bnms_pkg::MaxClasses
				: class_count;
			if (tot > bnms_pkg::MaxBoxes)
				tot = bnms_pkg::MaxBoxes;
			for (int k = 0; k < classes; k++) begin
				n = 0;
				for (int i = 0; i < tot; i++) begin
					if (present[i]) begin
						s = score[i][k];
						j = n;
						while (j > 0 && score[rank[j-1]][k] < s) begin
							rank[j] = rank[j-1];
							j--;
						end
						rank[j] = i;
						n++;
					end
				end
				for (int i = 0; i < n; i++) begin
					a = rank[i];
					if (score[a][k] != 16'd0) begin
						for (int m = i + 1; m < n; m++) begin
							b = rank[m];
							if (score[b][k] != 16'd0 && iou_over(a, b))
								score[b][k] = 16'd0;
						end
					end
				end
			end
		endfunction

		function void note(nms_txn_t t);
			nms_reply_t r;
			r.run_done = 1'b0;
			r.score_out = 16'd0;
			case (t.op)
				bnms_pkg::OP_LOAD_BOX: begin
					bx[t.box_index] = t.center_x;
					by[t.box_index] = t.center_y;
					bw[t.box_index] = t.box_width;
					bh[t.box_index] = t.box_height;
					present[t.box_index] = t.box_present;
				end
				bnms_pkg::OP_LOAD_SCORE: begin
					score[t.box_index][t.class_index] = t.score_in;
					score_set[t.box_index][t.class_index] = 1'b1;
				end
				bnms_pkg::OP_RUN: begin
					suppress(int'(t.box_total));
					r.run_done = 1'b1;
				end
				default: r.score_out = score[t.box_index][t.class_index];
			endcase
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check(logic done, logic [15:0] val);
			nms_reply_t e;
			if (expected_q.size() == 0) begin
				report("result with no transaction outstanding");
			end else begin
				e = expected_q.pop_front();
				if (done !== e.run_done)
					report($sformatf("run_done %0b, expected %0b", done, e.run_done));
				if (val !== e.score_out)
					report($sformatf("score_out %0d, expected %0d", val, e.score_out));
			end
		endtask
	endclass

	logic clk, arst_n, start, busy, strobe, cfg_we, cfg_index;
	logic [15:0] cfg_data;
	logic [1:0] op;
	logic [5:0] box_index;
	logic [3:0] class_index;
	logic [15:0] center_x, center_y, box_width, box_height, score_in;
	logic box_present;
	logic [6:0] box_total;
	logic run_done;
	logic [15:0] score_out;

	nms_scoreboard sb;
	int sent;

	box_non_max_suppression uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .box_index(box_index), .class_index(class_index),
		.center_x(center_x), .center_y(center_y), .box_width(box_width),
		.box_height(box_height), .box_present(box_present), .score_in(score_in),
		.box_total(box_total), .run_done(run_done), .score_out(score_out)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		if (strobe)
			sb.check(run_done, score_out);
	end

	task send(nms_txn_t t);
		op <= t.op;
		box_index <= t.box_index;
		class_index <= t.class_index;
		center_x <= t.center_x;
		center_y <= t.center_y;
		box_width <= t.box_width;
		box_height <= t.box_height;
		box_present <= t.box_present;
		score_in <= t.score_in;
		box_total <= t.box_total;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note(t);
		sent++;
	endtask

	task idle(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task drain;
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_cfg(logic idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bnms_pkg::CFG_THRESHOLD)
			sb.threshold = val;
		else
			sb.class_count = val[4:0];
	endtask

	function nms_txn_t blank(logic [1:0] o);
		nms_txn_t t;
		t.op = o;
		t.box_index = '0;
		t.class_index = '0;
		t.center_x = '0;
		t.center_y = '0;
		t.box_width = '0;
		t.box_height = '0;
		t.box_present = 1'b0;
		t.score_in = '0;
		t.box_total = '0;
		return t;
	endfunction

	function nms_txn_t box_txn(int b, int x, int y, int w, int h, bit p);
		nms_txn_t t;
		t = blank(bnms_pkg::OP_LOAD_BOX);
		t.box_index = 6'(b);
		t.center_x = 16'(x);
		t.center_y = 16'(y);
		t.box_width = 16'(w);
		t.box_height = 16'(h);
		t.box_present = p;
		return t;
	endfunction

	function nms_txn_t score_txn(logic [1:0] o, int b, int c, int s);
		nms_txn_t t;
		t = blank(o);
		t.box_index = 6'(b);
		t.class_index = 4'(c);
		t.score_in = 16'(s);
		return t;
	endfunction

	function nms_txn_t run_txn(int tot);
		nms_txn_t t;
		t = blank(bnms_pkg::OP_RUN);
		t.box_total = 7'(tot);
		return t;
	endfunction

	// A run may only rank boxes whose scores were all written for the active classes,
	// so the box count is cut at the first present box that lacks one.
	function int safe_total(int tot);
		int classes, lim;
		classes = sb.class_count > bnms_pkg::MaxClasses ? bnms_pkg::MaxClasses
			: sb.class_count;
		lim = tot > bnms_pkg::MaxBoxes ? bnms_pkg::MaxBoxes : tot;
		for (int i = 0; i < lim; i++)
			if (sb.present[i])
				for (int c = 0; c < classes; c++)
					if (!sb.score_set[i][c])
						return i;
		return tot;
	endfunction

	function nms_txn_t random_txn();
		nms_txn_t t;
		int sel, classes, b, c;
		classes = sb.class_count > bnms_pkg::MaxClasses ? bnms_pkg::MaxClasses
			: sb.class_count;
		t = blank(bnms_pkg::OP_LOAD_BOX);
		t.box_index = 6'($urandom_range(0, 99) < 80 ? $urandom_range(0, 7)
			: $urandom_range(0, 63));
		t.class_index = 4'((classes > 0 && $urandom_range(0, 99) < 75) ?
			$urandom_range(0, classes - 1) : $urandom_range(0, 15));
		if ($urandom_range(0, 99) < 80) begin
			t.center_x = 16'(30000 + $urandom_range(0, 4000));
			t.center_y = 16'(30000 + $urandom_range(0, 4000));
			t.box_width = 16'($urandom_range(1000, 12000));
			t.box_height = 16'($urandom_range(1000, 12000));
		end else begin
			t.center_x = 16'($urandom);
			t.center_y = 16'($urandom);
			t.box_width = 16'($urandom);
			t.box_height = 16'($urandom);
		end
		t.box_present = $urandom_range(0, 99) < 85;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			t.score_in = 16'd0;
		else if (sel < 15)
			t.score_in = 16'hFFFF;
		else if (sel < 35)
			t.score_in = 16'(100 * $urandom_range(1, 3));
		else
			t.score_in = 16'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 85)
			t.box_total = 7'($urandom_range(0, 9));
		else if (sel < 97)
			t.box_total = 7'($urandom_range(0, 64));
		else
			t.box_total = 7'($urandom_range(65, 127));
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			t.op = bnms_pkg::OP_LOAD_BOX;
		end else if (sel < 65) begin
			t.op = bnms_pkg::OP_LOAD_SCORE;
		end else if (sel < 75) begin
			t.op = bnms_pkg::OP_RUN;
			t.box_total = 7'(safe_total(int'(t.box_total)));
		end else begin
			t.op = bnms_pkg::OP_LOAD_SCORE;
			for (int k = 0; k < 8; k++) begin
				b = t.box_index;
				c = t.class_index;
				if (sb.score_set[b][c]) begin
					t.op = bnms_pkg::OP_READ;
					break;
				end
				t.box_index = 6'($urandom_range(0, 7));
				t.class_index = 4'($urandom_range(0, 15));
			end
		end
		return t;
	endfunction

	initial begin
		int idle_pct;
		logic [4:0] phase_classes[4];
		logic [15:0] phase_thr[4];
		sb = new();
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		op = bnms_pkg::OP_LOAD_BOX;
		box_index = '0;
		class_index = '0;
		center_x = '0;
		center_y = '0;
		box_width = '0;
		box_height = '0;
		box_present = 1'b0;
		score_in = '0;
		box_total = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two empty boxes have no union, so neither suppresses the other.
		send(box_txn(0, 0, 0, 0, 0, 1));
		send(box_txn(1, 0, 0, 0, 0, 1));
		send(score_txn(bnms_pkg::OP_LOAD_SCORE, 0, 0, 16'hFFFF));
		send(score_txn(bnms_pkg::OP_LOAD_SCORE, 1, 0, 16'hFFFF));
		send(run_txn(2));
		send(score_txn(bnms_pkg::OP_READ, 1, 0, 0));
		send(box_txn(2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		send(box_txn(3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		send(box_txn(63, 32768, 32768, 1000, 1000, 0));
		send(score_txn(bnms_pkg::OP_LOAD_SCORE, 2, 0, 100));
		send(score_txn(bnms_pkg::OP_LOAD_SCORE, 3, 0, 200));
		send(score_txn(bnms_pkg::OP_LOAD_SCORE, 63, 15, 16'hFFFF));
		send(score_txn(bnms_pkg::OP_LOAD_SCORE, 0, 0, 0));
		send(run_txn(127));
		send(score_txn(bnms_pkg::OP_READ, 2, 0, 0));
		send(score_txn(bnms_pkg::OP_READ, 3, 0, 0));
		send(score_txn(bnms_pkg::OP_READ, 63, 15, 0));
		send(score_txn(bnms_pkg::OP_READ, 0, 0, 0));
		write_cfg(bnms_pkg::CFG_CLASSES, 16'd0);
		send(run_txn(64));
		write_cfg(bnms_pkg::CFG_CLASSES, 16'd31);
		send(run_txn(safe_total(127)));
		write_cfg(bnms_pkg::CFG_THRESHOLD, 16'd0);
		write_cfg(bnms_pkg::CFG_CLASSES, 16'd1);
		send(run_txn(4));
		send(score_txn(bnms_pkg::OP_READ, 3, 0, 0));

		phase_thr[0] = 16'd29491;
		phase_thr[1] = 16'hFFFF;
		phase_thr[2] = 16'($urandom);
		phase_thr[3] = 16'd0;
		phase_classes[0] = 5'd1;
		phase_classes[1] = 5'd2;
		phase_classes[2] = 5'd4;
		phase_classes[3] = 5'd16;
		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(bnms_pkg::CFG_THRESHOLD, phase_thr[ph]);
			write_cfg(bnms_pkg::CFG_CLASSES, {11'd0, phase_classes[ph]});
			idle_pct = ph == 1 ? 78 : (ph == 3 ? 31 : 0);
			for (int n = 0; n < 355; n++) begin
				send(random_txn());
				if (ph == 2 && n % 60 < 20)
					idle(1 + (n % 5));
				else if ($urandom_range(0, 99) < idle_pct && (n % 100) < 70)
					idle($urandom_range(1, 12));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS box_non_max_suppression");
		else
			$display("FAIL box_non_max_suppression");
		$finish;
	end

	initial begin
		#(64'd50_000_000_000);
		$display("FAIL box_non_max_suppression");
		$finish;
	end
endmodule
